// ===== rtl/codon_translator_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is off while reset is asserted.
`ifndef CODON_TRANSLATOR_MACROS_SVH
`define CODON_TRANSLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codon_translator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codon_translator: next-cycle check failed");

`endif

// ===== rtl/ct_pkg.sv =====
package ct_pkg;

    typedef enum logic [1:0] {
        ST_AMINO   = 2'd0,
        ST_STOP    = 2'd1,
        ST_INVALID = 2'd2,
        ST_END     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_sequence;
    } item_t;

    typedef struct packed {
        logic [7:0] amino_acid;
        status_t    status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_t;

    localparam logic [1:0] BASE_U = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    localparam logic [7:0] STOP_MARK = 8'h2A;

    // Standard genetic code, indexed by first*16 + second*4 + third with
    // U=0, C=1, A=2, G=3. The first character sits in the top byte.
    localparam logic [8*64-1:0] CODE_STR =
        {"FFLLSSSSYY**CC*W", "LLLLPPPPHHQQRRRR",
         "IIIMTTTTNNKKSSRR", "VVVVAAAADDEEGGGG"};

    function automatic base_t decode_base(input logic [7:0] sym);
        logic [7:0] c;
        base_t      b;
        c = sym;
        if (sym >= 8'h61 && sym <= 8'h7A)
        begin
            c = sym - 8'd32;
        end
        b.ok   = 1'b1;
        b.code = BASE_U;
        case (c)
            8'h55, 8'h54: b.code = BASE_U;
            8'h43:        b.code = BASE_C;
            8'h41:        b.code = BASE_A;
            8'h47:        b.code = BASE_G;
            default:      b.ok   = 1'b0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] codon_lookup(input logic [5:0] idx);
        logic [8:0] pos;
        pos = {3'd0, 6'd63 - idx} << 3;
        return CODE_STR[pos +: 8];
    endfunction

endpackage

// ===== rtl/codon_translator.sv =====
// A symbol waits in the input register, its result in the result register.
// Throughput: one symbol per cycle unless stalled; the input register and the
// result register let a new beat in while a finished result waits to be taken.
// Reset clears the codon phase, the held bases, the halt flag and both
// valid flags; the payload registers are not reset.
`include "codon_translator_macros.svh"

module codon_translator
    import ct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    item_t      s1_item_reg;
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       halted_reg;
    logic       halted_next;
    logic       out_valid_reg;
    result_t    out_data_reg;

    logic       out_free;
    logic       s1_advance;
    logic       accept;
    logic       has_result;
    result_t    res_comb;
    base_t      base;
    logic [7:0] aa;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign base = decode_base(s1_item_reg.symbol);
    assign aa   = codon_lookup({pending_reg, base.code});

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pending_next        = pending_reg;
        phase_next          = phase_reg;
        halted_next         = halted_reg;
        has_result          = 1'b0;
        res_comb.amino_acid = 8'd0;
        res_comb.status     = ST_END;
        res_comb.last       = s1_item_reg.end_of_sequence;

        if (halted_reg)
        begin
            if (s1_item_reg.end_of_sequence)
            begin
                has_result = 1'b1;
            end
        end
        else if (!base.ok)
        begin
            has_result      = 1'b1;
            res_comb.status = ST_INVALID;
            halted_next     = 1'b1;
        end
        else if (phase_reg < 2'd2)
        begin
            pending_next = {pending_reg[1:0], base.code};
            phase_next   = phase_reg + 2'd1;
            has_result   = s1_item_reg.end_of_sequence;
        end
        else
        begin
            pending_next = 4'd0;
            phase_next   = 2'd0;
            has_result   = 1'b1;
            if (aa == STOP_MARK)
            begin
                halted_next     = 1'b1;
                res_comb.status = ST_STOP;
            end
            else
            begin
                res_comb.status     = ST_AMINO;
                res_comb.amino_acid = aa;
            end
        end

        // The end of a sequence always clears the codon phase, held bases and halt flag.
        if (s1_item_reg.end_of_sequence)
        begin
            pending_next = 4'd0;
            phase_next   = 2'd0;
            halted_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pending_reg   <= 4'd0;
            phase_reg     <= 2'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_advance)
            begin
                pending_reg <= pending_next;
                phase_reg   <= phase_next;
                halted_reg  <= halted_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_advance && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_advance && has_result)
        begin
            out_data_reg <= res_comb;
        end
    end

    `CT_ASSERT_SAME(a_phase_range, 1'b1, phase_reg != 2'd3)
    `CT_ASSERT_NEXT(a_end_clears, s1_advance && s1_item_reg.end_of_sequence,
        phase_reg == 2'd0 && !halted_reg && pending_reg == 4'd0)
    `CT_ASSERT_SAME(a_zero_letter, out_valid_reg && out_data_reg.status != ST_AMINO,
        out_data_reg.amino_acid == 8'd0)
    `CT_ASSERT_SAME(a_stall_cause, item_stall, s1_valid_reg && out_valid_reg)

endmodule
